// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: label");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition: label");

`endif

// File: rtl/i2ctrp_pkg.sv
// Types and constants of the I2C target register pointer.
package i2ctrp_pkg;

    localparam int BYTE_W = 8;
    localparam int PTR_W  = 2 * BYTE_W;
    localparam int OP_W   = 3;
    localparam int ACT_W  = 2;

    localparam logic [OP_W-1:0] OP_ADDR_WRITE = 3'd0;
    localparam logic [OP_W-1:0] OP_DATA_ACK   = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP       = 3'd2;
    localparam logic [OP_W-1:0] OP_READ       = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_NACK  = 3'd4;
    localparam logic [OP_W-1:0] OP_DISALLOWED = 3'd5;

    localparam logic [ACT_W-1:0] ACT_HOLD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ACK     = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RECOVER = 2'd2;

    typedef enum logic [1:0] {
        PH_ADDR_HIGH = 2'd0,
        PH_ADDR_LOW  = 2'd1,
        PH_WRITE     = 2'd2
    } t_phase;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic [ACT_W-1:0]  bus_action;
        logic              write_strobe;
        logic              read_strobe;
        logic [PTR_W-1:0]  access_address;
        logic [BYTE_W-1:0] write_data;
    } t_out_word;

endpackage

// File: rtl/i2ctrp_stage.sv
// Pipeline register stage with valid/stall handshake.
module i2ctrp_stage #(
    parameter type t_data = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_data i_data,
    output logic  o_stall,
    output logic  o_valid,
    output t_data o_data,
    input  logic  i_stall
);

    logic  r_valid;
    logic  n_valid;
    t_data r_data;
    logic  load;

    assign load    = !r_valid || !i_stall;
    assign o_stall = !load;
    assign n_valid = load ? i_valid : r_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

// File: rtl/i2ctrp_core.sv
// Event decode, phase and register pointer.
module i2ctrp_core
    import i2ctrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_word  i_word,
    output t_out_word o_word
);

    t_phase            r_phase;
    t_phase            n_phase;
    logic [PTR_W-1:0]  r_pointer;
    logic [PTR_W-1:0]  n_pointer;
    logic [PTR_W-1:0]  ptr_inc;

    assign ptr_inc = r_pointer + {{(PTR_W-1){1'b0}}, 1'b1};

    always_comb begin
        n_phase   = r_phase;
        n_pointer = r_pointer;
        o_word    = '0;
        o_word.bus_action = ACT_ACK;
        unique case (i_word.op)
            OP_ADDR_WRITE: begin
                n_phase = PH_ADDR_HIGH;
            end
            OP_DATA_ACK: begin
                unique case (r_phase)
                    PH_ADDR_HIGH: begin
                        n_pointer = {i_word.rx_byte, {BYTE_W{1'b0}}};
                        n_phase   = PH_ADDR_LOW;
                    end
                    PH_ADDR_LOW: begin
                        n_pointer = {r_pointer[PTR_W-1:BYTE_W], i_word.rx_byte};
                        n_phase   = PH_WRITE;
                    end
                    PH_WRITE: begin
                        o_word.write_strobe   = 1'b1;
                        o_word.access_address = r_pointer;
                        o_word.write_data     = i_word.rx_byte;
                        n_pointer             = ptr_inc;
                    end
                    default: begin
                    end
                endcase
            end
            OP_STOP, OP_READ_NACK: begin
            end
            OP_READ: begin
                o_word.read_strobe    = 1'b1;
                o_word.access_address = r_pointer;
                n_pointer             = ptr_inc;
            end
            OP_DISALLOWED: begin
                o_word.bus_action = ACT_HOLD;
            end
            default: begin
                o_word.bus_action = ACT_RECOVER;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_ADDR_HIGH;
            r_pointer <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_pointer <= n_pointer;
        end
    end

endmodule

// File: rtl/i2ctrp_top_note.sv
// Registered result checker-free pass: not used.

// File: rtl/i2c_target_register_pointer.sv
// A word accepted into the input register is decoded from there, and its result is loaded into
// the output register, which holds it until the receiver takes it.
// Throughput: one word per cycle while the output is not stalled; input register, decode logic, result register.
// The input side stalls only while both registers are full and the output is stalled.
// Reset: synchronous, active low; clears both stage valids, phase to high
// address byte and the pointer to zero.
`include "assert_macros.svh"
module i2c_target_register_pointer
    import i2ctrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_word  i_in_word,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall
);

    logic      mid_valid;
    t_in_word  mid_word;
    logic      mid_stall;
    t_out_word res_word;
    logic      fire;

    assign fire = mid_valid && !mid_stall;

    i2ctrp_stage #(.t_data(t_in_word)) u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_word),
        .o_stall (o_in_stall),
        .o_valid (mid_valid),
        .o_data  (mid_word),
        .i_stall (mid_stall)
    );

    i2ctrp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_word  (mid_word),
        .o_word  (res_word)
    );

    i2ctrp_stage #(.t_data(t_out_word)) u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mid_valid),
        .i_data  (res_word),
        .o_stall (mid_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_word),
        .i_stall (i_out_stall)
    );

    `ASSERT_CLK(a_in_stall_cause, i_clk, i_rst_n,
        o_in_stall |-> (o_out_valid && i_out_stall))
    `ASSERT_NEVER(a_both_strobes, i_clk, i_rst_n,
        o_out_valid && o_out_word.write_strobe && o_out_word.read_strobe)
    `ASSERT_CLK(a_wdata_zero, i_clk, i_rst_n,
        (o_out_valid && !o_out_word.write_strobe) |-> (o_out_word.write_data == '0))
    `ASSERT_NEVER(a_bad_action, i_clk, i_rst_n,
        o_out_valid && (o_out_word.bus_action == 2'd3))

endmodule

// File: tb/sv/register_pointer_checker.sv
// Checker for the I2C target register pointer: predicts each result word and compares.
`timescale 1ns / 1ps
module register_pointer_checker
    import i2ctrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_word  i_in_word,
    input  logic      i_in_stall,
    input  logic      i_out_valid,
    input  t_out_word i_out_word,
    input  logic      i_out_stall,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int REPORT_MAX = 10;

    t_phase           bus_phase;
    logic [PTR_W-1:0] reg_ptr;
    t_out_word        expected_results[$];
    int               fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_results.size();

    function automatic t_out_word predict_bus_event(input t_in_word w);
        t_out_word r;
        r = '0;
        r.bus_action = ACT_ACK;
        case (w.op)
            OP_ADDR_WRITE: bus_phase = PH_ADDR_HIGH;
            OP_DATA_ACK: begin
                case (bus_phase)
                    PH_ADDR_HIGH: begin
                        reg_ptr   = {w.rx_byte, {BYTE_W{1'b0}}};
                        bus_phase = PH_ADDR_LOW;
                    end
                    PH_ADDR_LOW: begin
                        reg_ptr   = {reg_ptr[PTR_W-1:BYTE_W], w.rx_byte};
                        bus_phase = PH_WRITE;
                    end
                    PH_WRITE: begin
                        r.write_strobe   = 1'b1;
                        r.access_address = reg_ptr;
                        r.write_data     = w.rx_byte;
                        reg_ptr          = reg_ptr + 1'b1;
                    end
                    default: ;
                endcase
            end
            OP_STOP, OP_READ_NACK: ;
            OP_READ: begin
                r.read_strobe    = 1'b1;
                r.access_address = reg_ptr;
                reg_ptr          = reg_ptr + 1'b1;
            end
            OP_DISALLOWED: r.bus_action = ACT_HOLD;
            default: r.bus_action = ACT_RECOVER;
        endcase
        return r;
    endfunction

    function automatic void note_failure(input string what, input t_out_word exp_w,
                                         input t_out_word act_w);
        if (fail_count < REPORT_MAX) begin
            $display("%0t: %s exp act=%0d w=%0b r=%0b addr=%h data=%h | got act=%0d w=%0b r=%0b addr=%h data=%h",
                     $realtime, what, exp_w.bus_action, exp_w.write_strobe, exp_w.read_strobe,
                     exp_w.access_address, exp_w.write_data, act_w.bus_action,
                     act_w.write_strobe, act_w.read_strobe, act_w.access_address,
                     act_w.write_data);
        end
        fail_count++;
    endfunction

    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            bus_phase = PH_ADDR_HIGH;
            reg_ptr   = '0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    note_failure("unexpected word", '0, i_out_word);
                end else begin
                    exp_w = expected_results.pop_front();
                    if (i_out_word.bus_action !== exp_w.bus_action
                        || i_out_word.write_strobe !== exp_w.write_strobe
                        || i_out_word.read_strobe !== exp_w.read_strobe
                        || i_out_word.access_address !== exp_w.access_address
                        || i_out_word.write_data !== exp_w.write_data) begin
                        note_failure("mismatch", exp_w, i_out_word);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(predict_bus_event(i_in_word));
            end
        end
    end

endmodule

// File: tb/sv/tb.sv
// Testbench top for the I2C target register pointer: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb;
    import i2ctrp_pkg::*;

    localparam logic [OP_W-1:0] OP_UNKNOWN = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE   = 3'd7;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    t_in_word  i_in_word = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;
    logic      i_out_stall = 1'b0;

    int fail_count;
    int pending;
    int words_sent = 0;
    int idle_pct = 19;
    int stall_pct = 85;
    int cycles = 0;
    logic start_hold = 1'b0;
    logic hold_off = 1'b0;

    i2c_target_register_pointer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_word (o_out_word),
        .i_out_stall(i_out_stall)
    );

    register_pointer_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .i_in_stall  (o_in_stall),
        .i_out_valid (o_out_valid),
        .i_out_word  (o_out_word),
        .i_out_stall (i_out_stall),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        i_out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    // long receiver hold-off so the block fills and stalls its input
    initial begin
        while (!start_hold) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    task automatic send_word(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] b);
        t_in_word w;
        w.op = op;
        w.rx_byte = b;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            i_in_word <= {OP_W'($urandom_range(7)), BYTE_W'($urandom_range(255))};
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
    endtask

    task automatic set_pointer_bytes();
        if ($urandom_range(9) == 0) begin
            send_word(OP_DATA_ACK, 8'hFF);
            send_word(OP_DATA_ACK, BYTE_W'($urandom_range(255, 250)));
        end else begin
            send_word(OP_DATA_ACK, BYTE_W'($urandom_range(255)));
            send_word(OP_DATA_ACK, BYTE_W'($urandom_range(255)));
        end
    endtask

    task automatic write_transfer();
        int n;
        n = $urandom_range(6);
        send_word(OP_ADDR_WRITE, BYTE_W'($urandom_range(255)));
        set_pointer_bytes();
        repeat (n) send_word(OP_DATA_ACK, BYTE_W'($urandom_range(255)));
        send_word(OP_STOP, BYTE_W'($urandom_range(255)));
    endtask

    task automatic read_transfer();
        int n;
        n = $urandom_range(6);
        if ($urandom_range(3) != 0) begin
            send_word(OP_ADDR_WRITE, BYTE_W'($urandom_range(255)));
            set_pointer_bytes();
            if ($urandom_range(1)) send_word(OP_STOP, BYTE_W'($urandom_range(255)));
        end
        send_word(OP_READ, BYTE_W'($urandom_range(255)));
        repeat (n) send_word(OP_READ, BYTE_W'($urandom_range(255)));
        send_word(OP_READ_NACK, BYTE_W'($urandom_range(255)));
        send_word(OP_STOP, BYTE_W'($urandom_range(255)));
    endtask

    task automatic random_until(input int target);
        int pick;
        while (words_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 45) write_transfer();
            else if (pick < 80) read_transfer();
            else if (pick < 90) begin
                // broken sequence: addressed, then cut short
                send_word(OP_ADDR_WRITE, BYTE_W'($urandom_range(255)));
                if ($urandom_range(1)) send_word(OP_DATA_ACK, BYTE_W'($urandom_range(255)));
                send_word(OP_STOP, BYTE_W'($urandom_range(255)));
            end else begin
                send_word(OP_W'($urandom_range(7)), BYTE_W'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset pointer, wrap on write and read, every event code
        send_word(OP_READ, 8'h00);
        send_word(OP_ADDR_WRITE, 8'hA5);
        send_word(OP_DATA_ACK, 8'hFF);
        send_word(OP_DATA_ACK, 8'hFF);
        send_word(OP_DATA_ACK, 8'h00);
        send_word(OP_DATA_ACK, 8'hFF);
        send_word(OP_STOP, 8'hFF);
        send_word(OP_ADDR_WRITE, 8'h00);
        send_word(OP_DATA_ACK, 8'hFF);
        send_word(OP_DATA_ACK, 8'hFF);
        send_word(OP_STOP, 8'h5A);
        send_word(OP_READ, 8'hFF);
        send_word(OP_READ, 8'h00);
        send_word(OP_READ_NACK, 8'hFF);
        send_word(OP_DISALLOWED, 8'hFF);
        send_word(OP_UNKNOWN, 8'hFF);
        send_word(OP_SPARE, 8'h00);
        send_word(OP_ADDR_WRITE, 8'hFF);
        send_word(OP_DATA_ACK, 8'h00);
        send_word(OP_ADDR_WRITE, 8'h00);
        send_word(OP_DATA_ACK, 8'h00);
        send_word(OP_DATA_ACK, 8'h00);
        send_word(OP_DATA_ACK, 8'h80);
        send_word(OP_STOP, 8'h00);

        random_until(540);
        idle_pct = 85;
        stall_pct <= 19;
        random_until(1050);
        idle_pct = 0;
        stall_pct <= 0;
        start_hold <= 1'b1;
        random_until(1570);
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
